/* src/mwsm_pkg.sv */
`default_nettype none

package mwsm_pkg;

  // Fixed point default: Q4.12
  localparam int FRAC_BITS_DEF = 12;

  // Register stages from input to output
  localparam int PIPE_DEPTH = 5;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LIN_DEADBAND = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIN_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANG_DEADBAND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANG_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GEOMETRY     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RPM_GAIN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT  = 3'd6;

  // Field widths
  localparam int VEL_W   = 16;
  localparam int MAG_W   = 15;
  localparam int GEOM_W  = 14;
  localparam int GAIN_W  = 16;
  localparam int SPEED_W = 16;

  // Register reset values
  localparam logic [MAG_W-1:0]  LIN_DEADBAND_RST = 15'd819;
  localparam logic [MAG_W-1:0]  LIN_LIMIT_RST    = 15'd2458;
  localparam logic [MAG_W-1:0]  ANG_DEADBAND_RST = 15'd1229;
  localparam logic [MAG_W-1:0]  ANG_LIMIT_RST    = 15'd6144;
  localparam logic [GEOM_W-1:0] GEOMETRY_RST     = 14'd1638;
  localparam logic [GAIN_W-1:0] RPM_GAIN_RST     = 16'd4108;
  localparam logic [MAG_W-1:0]  SPEED_LIMIT_RST  = 15'd5800;

endpackage

`default_nettype wire

/* src/mecanum_wheel_speed_mixer.sv */
// Mecanum wheel speed mixer. Takes one body velocity command (vel_x, vel_y,
// vel_rot, signed fixed point with FRAC_BITS fraction bits) per cycle and
// returns four saturated wheel rpm commands, one result per command, in
// order. Throughput is one transaction per clock unless the output stalls;
// the five register stages are axis deadband/clamp, geometry multiply,
// rotation shift and mecanum sums, rpm gain multiply, truncation and
// saturation. A stalled output holds the pipeline in place; in_ready drops
// only while all five stages hold a transaction and the output is not being
// taken. The configuration port is always ready and takes effect on the next
// command; write it only while the pipeline is empty.
`default_nettype none

module mecanum_wheel_speed_mixer #(
  parameter int FRAC_BITS = mwsm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // configuration
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [mwsm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [mwsm_pkg::CFG_DATA_W-1:0]      cfg_data,
  // command
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [mwsm_pkg::VEL_W-1:0]    in_vel_x,
  input  wire logic signed [mwsm_pkg::VEL_W-1:0]    in_vel_y,
  input  wire logic signed [mwsm_pkg::VEL_W-1:0]    in_vel_rot,
  // wheel speeds
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [mwsm_pkg::SPEED_W-1:0]       out_wheel1_speed,
  output logic signed [mwsm_pkg::SPEED_W-1:0]       out_wheel2_speed,
  output logic signed [mwsm_pkg::SPEED_W-1:0]       out_wheel3_speed,
  output logic signed [mwsm_pkg::SPEED_W-1:0]       out_wheel4_speed
);

  localparam int VW    = mwsm_pkg::VEL_W;
  localparam int MW_   = mwsm_pkg::MAG_W;
  localparam int DEPTH = mwsm_pkg::PIPE_DEPTH;
  // geometry * vz
  localparam int PW  = mwsm_pkg::GEOM_W + 1 + VW;
  // rotation term after the shift
  localparam int RW  = PW - FRAC_BITS;
  // vx +/- vy
  localparam int AW  = VW + 1;
  // mecanum sums
  localparam int SW  = ((RW > AW) ? RW : AW) + 1;
  // sum * gain
  localparam int GW  = SW + mwsm_pkg::GAIN_W + 1;
  // after truncation, plus one bit for negation
  localparam int QW  = GW - FRAC_BITS;
  localparam int NW  = QW + 1;
  localparam logic signed [GW-1:0] TRUNC_BIAS = GW'((2 ** FRAC_BITS) - 1);

  // ---------------------------------------------------------------
  // Configuration registers
  logic [MW_-1:0]                    lin_db_r, lin_lim_r, ang_db_r, ang_lim_r, spd_lim_r;
  logic [mwsm_pkg::GEOM_W-1:0]       geom_r;
  logic [mwsm_pkg::GAIN_W-1:0]       gain_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_db_r  <= mwsm_pkg::LIN_DEADBAND_RST;
      lin_lim_r <= mwsm_pkg::LIN_LIMIT_RST;
      ang_db_r  <= mwsm_pkg::ANG_DEADBAND_RST;
      ang_lim_r <= mwsm_pkg::ANG_LIMIT_RST;
      geom_r    <= mwsm_pkg::GEOMETRY_RST;
      gain_r    <= mwsm_pkg::RPM_GAIN_RST;
      spd_lim_r <= mwsm_pkg::SPEED_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        mwsm_pkg::REG_LIN_DEADBAND: lin_db_r  <= cfg_data[MW_-1:0];
        mwsm_pkg::REG_LIN_LIMIT:    lin_lim_r <= cfg_data[MW_-1:0];
        mwsm_pkg::REG_ANG_DEADBAND: ang_db_r  <= cfg_data[MW_-1:0];
        mwsm_pkg::REG_ANG_LIMIT:    ang_lim_r <= cfg_data[MW_-1:0];
        mwsm_pkg::REG_GEOMETRY:     geom_r    <= cfg_data[mwsm_pkg::GEOM_W-1:0];
        mwsm_pkg::REG_RPM_GAIN:     gain_r    <= cfg_data[mwsm_pkg::GAIN_W-1:0];
        mwsm_pkg::REG_SPEED_LIMIT:  spd_lim_r <= cfg_data[MW_-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Pipeline control: a stage moves when it is empty or the next one moves
  logic [DEPTH-1:0] vld_r;
  logic [DEPTH-1:0] adv;

  always_comb begin
    adv[DEPTH-1] = !vld_r[DEPTH-1] || out_ready;
    for (int k = DEPTH - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < DEPTH; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: deadband, then clamp
  function automatic logic signed [VW-1:0] condition(
    input logic signed [VW-1:0] v,
    input logic [MW_-1:0]       db,
    input logic [MW_-1:0]       lim
  );
    logic signed [VW:0] vw;
    logic        [VW:0] mag;
    logic signed [VW:0] lim_s;
    vw    = {v[VW-1], v};
    mag   = vw[VW] ? -vw : vw;
    lim_s = {2'b00, lim};
    if (mag < {2'b00, db}) begin
      vw = '0;
    end
    if (vw > lim_s) begin
      vw = lim_s;
    end else if (vw < -lim_s) begin
      vw = -lim_s;
    end
    return vw[VW-1:0];
  endfunction

  logic signed [VW-1:0] vx1_r, vy1_r, vz1_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      vx1_r <= condition(in_vel_x,   lin_db_r, lin_lim_r);
      vy1_r <= condition(in_vel_y,   lin_db_r, lin_lim_r);
      vz1_r <= condition(in_vel_rot, ang_db_r, ang_lim_r);
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: geometry * vz, vx +/- vy
  logic signed [PW-1:0] rot2_nxt, rot2_r;
  logic signed [AW-1:0] dif2_nxt, sum2_nxt, dif2_r, sum2_r;

  assign rot2_nxt = $signed({1'b0, geom_r}) * vz1_r;
  assign dif2_nxt = AW'(vx1_r) - AW'(vy1_r);
  assign sum2_nxt = AW'(vx1_r) + AW'(vy1_r);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      rot2_r <= rot2_nxt;
      dif2_r <= dif2_nxt;
      sum2_r <= sum2_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Stage 3: floor shift of the rotation term, four mecanum sums
  logic signed [RW-1:0] rot3;
  logic signed [SW-1:0] mix3_nxt [4];
  logic signed [SW-1:0] mix3_r   [4];

  assign rot3 = rot2_r[PW-1:FRAC_BITS];

  always_comb begin
    mix3_nxt[0] = SW'(dif2_r) + SW'(rot3);
    mix3_nxt[1] = SW'(sum2_r) - SW'(rot3);
    mix3_nxt[2] = SW'(sum2_r) + SW'(rot3);
    mix3_nxt[3] = SW'(dif2_r) - SW'(rot3);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      mix3_r <= mix3_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Stage 4: rpm gain
  logic signed [GW-1:0] scl4_nxt [4];
  logic signed [GW-1:0] scl4_r   [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      scl4_nxt[k] = mix3_r[k] * $signed({1'b0, gain_r});
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      scl4_r <= scl4_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Stage 5: truncate toward zero, mirror wheels two and four, saturate
  logic signed [mwsm_pkg::SPEED_W-1:0] spd5_nxt [4];
  logic signed [mwsm_pkg::SPEED_W-1:0] spd5_r   [4];

  always_comb begin
    logic signed [GW-1:0] t;
    logic signed [QW-1:0] q;
    logic signed [NW-1:0] w;
    logic signed [NW-1:0] lim;
    lim = NW'({1'b0, spd_lim_r});
    for (int k = 0; k < 4; k++) begin
      t = scl4_r[k][GW-1] ? scl4_r[k] + TRUNC_BIAS : scl4_r[k];
      q = t[GW-1:FRAC_BITS];
      // odd lanes are wheels two and four
      w = (k % 2 == 1) ? -NW'(q) : NW'(q);
      if (w > lim) begin
        w = lim;
      end else if (w < -lim) begin
        w = -lim;
      end
      spd5_nxt[k] = w[mwsm_pkg::SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      spd5_r <= spd5_nxt;
    end
  end

  assign out_wheel1_speed = spd5_r[0];
  assign out_wheel2_speed = spd5_r[1];
  assign out_wheel3_speed = spd5_r[2];
  assign out_wheel4_speed = spd5_r[3];

endmodule

`default_nettype wire

/* src/mwsm_checker.sv */
`default_nettype none

module mwsm_checker (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 cfg_valid,
  input wire logic                                 cfg_ready,
  input wire logic [mwsm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input wire logic [mwsm_pkg::CFG_DATA_W-1:0]      cfg_data,
  input wire logic                                 in_valid,
  input wire logic                                 in_ready,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic signed [mwsm_pkg::SPEED_W-1:0]  out_wheel1_speed,
  input wire logic signed [mwsm_pkg::SPEED_W-1:0]  out_wheel2_speed,
  input wire logic signed [mwsm_pkg::SPEED_W-1:0]  out_wheel3_speed,
  input wire logic signed [mwsm_pkg::SPEED_W-1:0]  out_wheel4_speed
);

  localparam int SPW = mwsm_pkg::SPEED_W;

  logic [mwsm_pkg::MAG_W-1:0] spd_lim_r;
  logic [3:0]                 inflight_r;
  logic                       in_acc, out_acc;

  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  // shadow of the speed limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_lim_r <= mwsm_pkg::SPEED_LIMIT_RST;
    end else if (cfg_valid && cfg_ready && cfg_index == mwsm_pkg::REG_SPEED_LIMIT) begin
      spd_lim_r <= cfg_data[mwsm_pkg::MAG_W-1:0];
    end
  end

  // transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + {3'd0, in_acc} - {3'd0, out_acc};
    end
  end

  function automatic logic within_lim(
    input logic signed [SPW-1:0]         w,
    input logic [mwsm_pkg::MAG_W-1:0]    l
  );
    logic signed [SPW:0] ws;
    logic signed [SPW:0] ls;
    ws = {w[SPW-1], w};
    ls = {2'b00, l};
    return (ws <= ls) && (ws >= -ls);
  endfunction

  // a held result does not change
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_wheel1_speed) &&
      $stable(out_wheel2_speed) && $stable(out_wheel3_speed) &&
      $stable(out_wheel4_speed))
    else $error("stalled wheel speeds changed");

  // input backpressure only comes from a blocked output
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without output stall");

  // no more transactions in flight than pipeline stages, and no output with none in flight
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= 4'(mwsm_pkg::PIPE_DEPTH) && !(out_valid && inflight_r == 4'd0))
    else $error("pipeline occupancy out of range");

  // every wheel speed respects the speed limit
  a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> within_lim(out_wheel1_speed, spd_lim_r) &&
      within_lim(out_wheel2_speed, spd_lim_r) &&
      within_lim(out_wheel3_speed, spd_lim_r) &&
      within_lim(out_wheel4_speed, spd_lim_r))
    else $error("wheel speed beyond speed limit");

endmodule

bind mecanum_wheel_speed_mixer mwsm_checker u_mwsm_checker (.*);

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam logic [mwsm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;  // past the register list
  localparam int HOLD_CYCLES = 64;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 90;
  localparam int NUM_ROWS = 22;

  // Index 0 is wheel one
  typedef logic [3:0][mwsm_pkg::SPEED_W-1:0] wheel_speeds_t;

  typedef enum int {KEEP, SET_EXTREME, SET_ZERO, SET_CROSSED, SET_NO_SPEED,
                    SET_DEFAULT} setting_t;

  typedef struct {
    setting_t setting;
    int       vx, vy, vz;
    bit       fixed;
    int       w1, w2, w3, w4;
  } command_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mwsm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mwsm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [mwsm_pkg::VEL_W-1:0] in_vel_x = '0;
  logic signed [mwsm_pkg::VEL_W-1:0] in_vel_y = '0;
  logic signed [mwsm_pkg::VEL_W-1:0] in_vel_rot = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [mwsm_pkg::SPEED_W-1:0] out_wheel1_speed;
  logic signed [mwsm_pkg::SPEED_W-1:0] out_wheel2_speed;
  logic signed [mwsm_pkg::SPEED_W-1:0] out_wheel3_speed;
  logic signed [mwsm_pkg::SPEED_W-1:0] out_wheel4_speed;

  // Register copy used for prediction
  logic [mwsm_pkg::MAG_W-1:0]  lin_deadband = mwsm_pkg::LIN_DEADBAND_RST;
  logic [mwsm_pkg::MAG_W-1:0]  lin_limit    = mwsm_pkg::LIN_LIMIT_RST;
  logic [mwsm_pkg::MAG_W-1:0]  ang_deadband = mwsm_pkg::ANG_DEADBAND_RST;
  logic [mwsm_pkg::MAG_W-1:0]  ang_limit    = mwsm_pkg::ANG_LIMIT_RST;
  logic [mwsm_pkg::GEOM_W-1:0] geometry     = mwsm_pkg::GEOMETRY_RST;
  logic [mwsm_pkg::GAIN_W-1:0] rpm_gain     = mwsm_pkg::RPM_GAIN_RST;
  logic [mwsm_pkg::MAG_W-1:0]  speed_limit  = mwsm_pkg::SPEED_LIMIT_RST;

  wheel_speeds_t speeds_due[$];
  int errors = 0;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int holdoff_kicks = 0;
  int holdoff_seen = 0;
  int hold_left = 0;

  // Directed commands; typed speeds only where they are obvious
  command_row_t rows [0:NUM_ROWS-1] = '{
    '{KEEP, 0, 0, 0, 1'b1, 0, 0, 0, 0},
    '{KEEP, 818, -818, 1228, 1'b1, 0, 0, 0, 0},
    '{KEEP, -818, 818, -1228, 1'b1, 0, 0, 0, 0},
    '{KEEP, 819, -819, 1229, 1'b0, 0, 0, 0, 0},
    '{KEEP, 32767, 0, 0, 1'b0, 0, 0, 0, 0},
    '{KEEP, -32768, -32768, -32768, 1'b0, 0, 0, 0, 0},
    '{KEEP, 0, 0, 32767, 1'b0, 0, 0, 0, 0},
    '{KEEP, 0, -32768, 0, 1'b0, 0, 0, 0, 0},
    '{SET_EXTREME, -32768, 0, 0, 1'b1, -32767, 32767, -32767, 32767},
    '{KEEP, 32767, 32767, 32767, 1'b0, 0, 0, 0, 0},
    '{KEEP, 1, -1, -1, 1'b0, 0, 0, 0, 0},
    '{KEEP, 0, 0, -1, 1'b0, 0, 0, 0, 0},
    '{SET_ZERO, 32767, -32768, 32767, 1'b1, 0, 0, 0, 0},
    '{KEEP, -32768, -32768, -32768, 1'b1, 0, 0, 0, 0},
    '{SET_CROSSED, 20000, 0, 0, 1'b1, 1000, -1000, 1000, -1000},
    '{KEEP, 19999, -19999, 29999, 1'b1, 0, 0, 0, 0},
    '{KEEP, 0, 0, -30000, 1'b1, -500, -500, -500, -500},
    '{KEEP, -20000, 20000, 30000, 1'b0, 0, 0, 0, 0},
    '{SET_NO_SPEED, 32767, 32767, 32767, 1'b1, 0, 0, 0, 0},
    '{KEEP, -32768, 12345, -4321, 1'b1, 0, 0, 0, 0},
    '{SET_DEFAULT, 1000, 2000, -3000, 1'b0, 0, 0, 0, 0},
    '{KEEP, -1000, 500, 3000, 1'b0, 0, 0, 0, 0}
  };

  mecanum_wheel_speed_mixer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_vel_x         (in_vel_x),
    .in_vel_y         (in_vel_y),
    .in_vel_rot       (in_vel_rot),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_wheel1_speed (out_wheel1_speed),
    .out_wheel2_speed (out_wheel2_speed),
    .out_wheel3_speed (out_wheel3_speed),
    .out_wheel4_speed (out_wheel4_speed)
  );

  always #5 clk = ~clk;

  // Deadband first, then magnitude clamp
  function automatic longint shape_axis(longint v, longint deadband, longint limit);
    longint mag;
    mag = (v < 0) ? -v : v;
    if (mag < deadband) v = 0;
    if (v > limit) v = limit;
    if (v < -limit) v = -limit;
    return v;
  endfunction

  function automatic logic [mwsm_pkg::SPEED_W-1:0] clip_speed(longint v, longint limit);
    if (v > limit) v = limit;
    if (v < -limit) v = -limit;
    return mwsm_pkg::SPEED_W'(v);
  endfunction

  // Inverse kinematics: rotation term floors, gain scaling truncates toward zero
  function automatic wheel_speeds_t mix_wheel_speeds(logic [mwsm_pkg::VEL_W-1:0] vel_x,
                                                     logic [mwsm_pkg::VEL_W-1:0] vel_y,
                                                     logic [mwsm_pkg::VEL_W-1:0] vel_rot);
    longint vx, vy, vz, rot, prod, w;
    longint sums [4];
    wheel_speeds_t speeds;
    vx = shape_axis(longint'($signed(vel_x)), longint'(lin_deadband), longint'(lin_limit));
    vy = shape_axis(longint'($signed(vel_y)), longint'(lin_deadband), longint'(lin_limit));
    vz = shape_axis(longint'($signed(vel_rot)), longint'(ang_deadband),
                    longint'(ang_limit));
    rot = (longint'(geometry) * vz) >>> mwsm_pkg::FRAC_BITS_DEF;
    sums[0] = vx - vy + rot;
    sums[1] = vx + vy - rot;
    sums[2] = vx + vy + rot;
    sums[3] = vx - vy - rot;
    for (int k = 0; k < 4; k++) begin
      prod = sums[k] * longint'(rpm_gain);
      w = (prod < 0) ? -((-prod) >>> mwsm_pkg::FRAC_BITS_DEF)
                     : (prod >>> mwsm_pkg::FRAC_BITS_DEF);
      // wheels two and four are mounted mirrored
      if (k % 2 == 1) w = -w;
      speeds[k] = clip_speed(w, longint'(speed_limit));
    end
    return speeds;
  endfunction

  // Update the register copy; unknown indexes are dropped
  function automatic void track_reg_write(logic [mwsm_pkg::CFG_IDX_W-1:0] idx,
                                          logic [mwsm_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      mwsm_pkg::REG_LIN_DEADBAND: lin_deadband = data[mwsm_pkg::MAG_W-1:0];
      mwsm_pkg::REG_LIN_LIMIT:    lin_limit    = data[mwsm_pkg::MAG_W-1:0];
      mwsm_pkg::REG_ANG_DEADBAND: ang_deadband = data[mwsm_pkg::MAG_W-1:0];
      mwsm_pkg::REG_ANG_LIMIT:    ang_limit    = data[mwsm_pkg::MAG_W-1:0];
      mwsm_pkg::REG_GEOMETRY:     geometry     = data[mwsm_pkg::GEOM_W-1:0];
      mwsm_pkg::REG_RPM_GAIN:     rpm_gain     = data[mwsm_pkg::GAIN_W-1:0];
      mwsm_pkg::REG_SPEED_LIMIT:  speed_limit  = data[mwsm_pkg::MAG_W-1:0];
      default: ;
    endcase
  endfunction

  // Leaves cfg_valid high so back-to-back writes need no low step
  task automatic cfg_write(input logic [mwsm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mwsm_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    track_reg_write(idx, data);
  endtask

  task automatic program_regs(input logic [mwsm_pkg::CFG_DATA_W-1:0] vals [7]);
    for (int i = 0; i < 7; i++) cfg_write(mwsm_pkg::CFG_IDX_W'(i), vals[i]);
    cfg_write(REG_UNUSED, mwsm_pkg::CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input setting_t s);
    logic [mwsm_pkg::CFG_DATA_W-1:0] vals [7];
    vals[mwsm_pkg::REG_LIN_DEADBAND] = 16'(mwsm_pkg::LIN_DEADBAND_RST);
    vals[mwsm_pkg::REG_LIN_LIMIT]    = 16'(mwsm_pkg::LIN_LIMIT_RST);
    vals[mwsm_pkg::REG_ANG_DEADBAND] = 16'(mwsm_pkg::ANG_DEADBAND_RST);
    vals[mwsm_pkg::REG_ANG_LIMIT]    = 16'(mwsm_pkg::ANG_LIMIT_RST);
    vals[mwsm_pkg::REG_GEOMETRY]     = 16'(mwsm_pkg::GEOMETRY_RST);
    vals[mwsm_pkg::REG_RPM_GAIN]     = 16'(mwsm_pkg::RPM_GAIN_RST);
    vals[mwsm_pkg::REG_SPEED_LIMIT]  = 16'(mwsm_pkg::SPEED_LIMIT_RST);
    case (s)
      SET_EXTREME: begin
        // over-wide values: top bits must be dropped
        vals[mwsm_pkg::REG_LIN_DEADBAND] = 16'h8000;
        vals[mwsm_pkg::REG_LIN_LIMIT]    = 16'h7FFF;
        vals[mwsm_pkg::REG_ANG_DEADBAND] = 16'h8000;
        vals[mwsm_pkg::REG_ANG_LIMIT]    = 16'hFFFF;
        vals[mwsm_pkg::REG_GEOMETRY]     = 16'hFFFF;
        vals[mwsm_pkg::REG_RPM_GAIN]     = 16'hFFFF;
        vals[mwsm_pkg::REG_SPEED_LIMIT]  = 16'hFFFF;
      end
      SET_ZERO: foreach (vals[i]) vals[i] = '0;
      SET_CROSSED: begin
        // deadbands above limits; unity geometry and gain
        vals[mwsm_pkg::REG_LIN_DEADBAND] = 16'd20000;
        vals[mwsm_pkg::REG_LIN_LIMIT]    = 16'd1000;
        vals[mwsm_pkg::REG_ANG_DEADBAND] = 16'd30000;
        vals[mwsm_pkg::REG_ANG_LIMIT]    = 16'd500;
        vals[mwsm_pkg::REG_GEOMETRY]     = 16'd4096;
        vals[mwsm_pkg::REG_RPM_GAIN]     = 16'd4096;
        vals[mwsm_pkg::REG_SPEED_LIMIT]  = 16'd32767;
      end
      SET_NO_SPEED: vals[mwsm_pkg::REG_SPEED_LIMIT] = '0;
      default: ;
    endcase
    program_regs(vals);
  endtask

  function automatic logic [mwsm_pkg::CFG_DATA_W-1:0] rand_reg_value(int typical_max);
    case ($urandom_range(0, 7))
      0: return mwsm_pkg::CFG_DATA_W'($urandom_range(0, 65535));
      1: return '0;
      default: return mwsm_pkg::CFG_DATA_W'($urandom_range(0, typical_max));
    endcase
  endfunction

  task automatic random_setting(input int phase);
    logic [mwsm_pkg::CFG_DATA_W-1:0] vals [7];
    vals[mwsm_pkg::REG_LIN_DEADBAND] = rand_reg_value(1500);
    vals[mwsm_pkg::REG_LIN_LIMIT]    = rand_reg_value(8192);
    vals[mwsm_pkg::REG_ANG_DEADBAND] = rand_reg_value(1500);
    vals[mwsm_pkg::REG_ANG_LIMIT]    = rand_reg_value(12000);
    vals[mwsm_pkg::REG_GEOMETRY]     = rand_reg_value(16383);
    vals[mwsm_pkg::REG_RPM_GAIN]     = rand_reg_value(65535);
    vals[mwsm_pkg::REG_SPEED_LIMIT]  = rand_reg_value(8000);
    if (phase % 6 == 5) begin
      // widest limits and gain, no deadband
      foreach (vals[i]) vals[i] = 16'hFFFF;
      vals[mwsm_pkg::REG_LIN_DEADBAND] = '0;
      vals[mwsm_pkg::REG_ANG_DEADBAND] = '0;
    end
    program_regs(vals);
  endtask

  // Mix of full-range values and values straddling the thresholds
  function automatic logic [mwsm_pkg::VEL_W-1:0] rand_vel(int deadband, int limit);
    int sel, m;
    logic [mwsm_pkg::VEL_W-1:0] v;
    sel = $urandom_range(0, 9);
    case (sel)
      0: v = 16'h8000;
      1: v = 16'h7FFF;
      2: v = '0;
      3, 4, 5: begin
        m = ((sel == 5) ? limit : deadband) + $urandom_range(0, 2) - 1;
        if (m < 0) m = 0;
        v = $urandom_range(0, 1) ? mwsm_pkg::VEL_W'(-m) : mwsm_pkg::VEL_W'(m);
      end
      default: v = mwsm_pkg::VEL_W'($urandom);
    endcase
    return v;
  endfunction

  // One command transaction, with an optional gap before it
  task automatic offer_command(input logic [mwsm_pkg::VEL_W-1:0] vx,
                               input logic [mwsm_pkg::VEL_W-1:0] vy,
                               input logic [mwsm_pkg::VEL_W-1:0] vz, input bit fixed,
                               input wheel_speeds_t fixed_speeds);
    if (snd_idle_pct != 0 && $urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < snd_idle_pct);
    end
    in_valid   <= 1'b1;
    in_vel_x   <= vx;
    in_vel_y   <= vy;
    in_vel_rot <= vz;
    do @(posedge clk); while (!in_ready);
    speeds_due.push_back(fixed ? fixed_speeds : mix_wheel_speeds(vx, vy, vz));
  endtask

  // Pipeline empty before any register write
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (speeds_due.size() != 0) @(posedge clk);
    repeat (mwsm_pkg::PIPE_DEPTH + 2) @(posedge clk);
  endtask

  // Result side: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (holdoff_seen != holdoff_kicks) begin
      holdoff_seen = holdoff_kicks;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  // Compare each result transaction against the oldest expectation
  always @(posedge clk) begin : result_check
    wheel_speeds_t got, due;
    if (rst_n && out_valid && out_ready) begin
      got = {out_wheel4_speed, out_wheel3_speed, out_wheel2_speed, out_wheel1_speed};
      if (speeds_due.size() == 0) begin
        $display("%0t: unexpected result, got %0d %0d %0d %0d", $time,
                 $signed(got[0]), $signed(got[1]), $signed(got[2]), $signed(got[3]));
        errors++;
      end else begin
        due = speeds_due.pop_front();
        for (int k = 0; k < 4; k++) begin
          if (got[k] !== due[k]) begin
            $display("%0t: wheel%0d speed expected %0d, got %0d", $time, k + 1,
                     $signed(due[k]), $signed(got[k]));
            errors++;
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin : stimulus
    wheel_speeds_t typed;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed commands, no idling
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (rows[i].setting != KEEP) begin
        wait_drained();
        apply_setting(rows[i].setting);
      end
      typed = {16'(rows[i].w4), 16'(rows[i].w3), 16'(rows[i].w2), 16'(rows[i].w1)};
      offer_command(16'(rows[i].vx), 16'(rows[i].vy), 16'(rows[i].vz), rows[i].fixed,
                    typed);
    end

    // Random phases, each with its own registers and idling pattern
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      random_setting(ph);
      case (ph % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 87; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 87; end
        default: begin snd_idle_pct = 29; rcv_stall_pct = 29; end
      endcase
      // long receiver hold-off while commands keep coming
      if (ph % 4 == 0 && ph != 0) holdoff_kicks++;
      repeat (PHASE_ITEMS) begin
        offer_command(rand_vel(lin_deadband, lin_limit), rand_vel(lin_deadband, lin_limit),
                      rand_vel(ang_deadband, ang_limit), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (speeds_due.size() != 0) @(posedge clk);
    repeat (2 * mwsm_pkg::PIPE_DEPTH) @(posedge clk);
    if (errors == 0 && speeds_due.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
